// ===== rtl/mre_pkg.sv =====
// shared constants, types and codes for the midpoint ellipse rasterizer
package mre_pkg;

	localparam int COORD_BITS    = 11;
	localparam int AXIS_BITS     = 10;
	localparam int COLOR_BITS    = 4;
	localparam int OUT_BITS      = COORD_BITS + 2;
	localparam int SQ_BITS       = 2 * AXIS_BITS;
	localparam int SLOPE_BITS    = 3 * AXIS_BITS + 2;
	localparam int MUL_BITS      = 2 * AXIS_BITS + 2;
	localparam int PROD_BITS     = 2 * MUL_BITS;
	localparam int DEC_BITS      = 4 * AXIS_BITS + 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = (COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_SEMI_AXIS_X = 3'd2,
		REG_SEMI_AXIS_Y = 3'd3,
		REG_PIXEL_COLOR = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		PH_DONE = 2'd0,
		PH_R1   = 2'd1,
		PH_R2   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] center_x;
		logic [COORD_BITS-1:0] center_y;
		logic [AXIS_BITS-1:0]  semi_axis_x;
		logic [AXIS_BITS-1:0]  semi_axis_y;
		logic [COLOR_BITS-1:0] pixel_color;
	} cfg_t;

endpackage

// ===== rtl/mre_mul.sv =====
// shared unsigned multiplier with registered product
module mre_mul (
	input  logic                           clk,
	input  logic [mre_pkg::MUL_BITS-1:0]   op_a,
	input  logic [mre_pkg::MUL_BITS-1:0]   op_b,
	output logic [mre_pkg::PROD_BITS-1:0]  prod
);

	localparam int PW = mre_pkg::PROD_BITS;

	logic [PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PW'(op_a) * PW'(op_b);
	end

	assign prod = prod_q;

endmodule

// ===== rtl/mre_cfg.sv =====
// configuration register file: center, semi-axes and color
module mre_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [mre_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [mre_pkg::CFG_DATA_BITS-1:0]   wr_data,
	output mre_pkg::cfg_t                       cfg
);

	localparam int CW = mre_pkg::COORD_BITS;
	localparam int AW = mre_pkg::AXIS_BITS;
	localparam int KW = mre_pkg::COLOR_BITS;

	mre_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= '0;
			cfg_q.center_y    <= '0;
			cfg_q.semi_axis_x <= '0;
			cfg_q.semi_axis_y <= '0;
			cfg_q.pixel_color <= '1;
		end else if (wr_en) begin
			unique case (wr_index)
				mre_pkg::REG_CENTER_X:    cfg_q.center_x    <= CW'(wr_data);
				mre_pkg::REG_CENTER_Y:    cfg_q.center_y    <= CW'(wr_data);
				mre_pkg::REG_SEMI_AXIS_X: cfg_q.semi_axis_x <= AW'(wr_data);
				mre_pkg::REG_SEMI_AXIS_Y: cfg_q.semi_axis_y <= AW'(wr_data);
				mre_pkg::REG_PIXEL_COLOR: cfg_q.pixel_color <= KW'(wr_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/midpoint_ellipse_rasterizer.sv =====
// top level: step sequencer and datapath of the midpoint ellipse rasterizer
//
//  channel   handshake                   payload
//  item      item_valid / item_stall     restart
//  result    result_valid / result_stall right_x left_x lower_y upper_y color_out
//                                        point_valid last_point
//  config    cfg_valid / cfg_ready       cfg_index cfg_data
//
// one transaction per item; item_stall is high from acceptance until the result is staged
// restart: a^2, b^2, a^2*b, start values, emit; advance: a^2, b^2, step x/y and d, emit,
// forming the region-2 start value first when crossing; after the end an advance only emits;
// one 22x22 multiplier serves all; a full result register lets the next item in while it waits
// asynchronous active-low reset clears all state, phase resets to done, color to 15
module midpoint_ellipse_rasterizer (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       item_valid,
	output logic                                       item_stall,
	input  logic                                       restart,
	output logic                                       result_valid,
	input  logic                                       result_stall,
	output logic signed [mre_pkg::OUT_BITS-1:0]        right_x,
	output logic signed [mre_pkg::OUT_BITS-1:0]        left_x,
	output logic signed [mre_pkg::OUT_BITS-1:0]        lower_y,
	output logic signed [mre_pkg::OUT_BITS-1:0]        upper_y,
	output logic [mre_pkg::COLOR_BITS-1:0]             color_out,
	output logic                                       point_valid,
	output logic                                       last_point,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [mre_pkg::CFG_IDX_BITS-1:0]           cfg_index,
	input  logic [mre_pkg::CFG_DATA_BITS-1:0]          cfg_data
);

	localparam int AW = mre_pkg::AXIS_BITS;
	localparam int SW = mre_pkg::SLOPE_BITS;
	localparam int QW = mre_pkg::SQ_BITS;
	localparam int MW = mre_pkg::MUL_BITS;
	localparam int PW = mre_pkg::PROD_BITS;
	localparam int DW = mre_pkg::DEC_BITS;
	localparam int OW = mre_pkg::OUT_BITS;
	localparam int KW = mre_pkg::COLOR_BITS;

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00_0000_0000_0001,
		ST_SQ_A   = 14'b00_0000_0000_0010,
		ST_SQ_B   = 14'b00_0000_0000_0100,
		ST_SQ_C   = 14'b00_0000_0000_1000,
		ST_RS_SET = 14'b00_0000_0001_0000,
		ST_TR_YY  = 14'b00_0000_0010_0000,
		ST_TR_BT  = 14'b00_0000_0100_0000,
		ST_TR_AY  = 14'b00_0000_1000_0000,
		ST_TR_AB  = 14'b00_0001_0000_0000,
		ST_TR_FIN = 14'b00_0010_0000_0000,
		ST_UPD1   = 14'b00_0100_0000_0000,
		ST_UPD2   = 14'b00_1000_0000_0000,
		ST_EMIT   = 14'b01_0000_0000_0000,
		ST_SPARE  = 14'b10_0000_0000_0000
	} state_t;

	state_t            state_q;
	mre_pkg::phase_t   phase_q;
	mre_pkg::cfg_t     cfg;

	logic [AW-1:0] x_q, y_q;
	logic [SW-1:0] sx_q, sy_q;
	logic [DW-1:0] d_q;
	logic [QW-1:0] a2_q, b2_q;
	logic [MW-1:0] tmp_q;
	logic          restart_q;
	logic          sx_add_q, sy_sub_q;
	logic          pend_valid_q, pend_last_q;

	logic          res_valid_q;
	logic [OW-1:0] res_right_q, res_left_q, res_lower_q, res_upper_q;
	logic [KW-1:0] res_color_q;
	logic          res_point_q, res_last_q;

	logic [MW-1:0] op_a, op_b;
	logic [PW-1:0] prod;
	logic [MW-1:0] t_val, ym_val;
	logic [DW-1:0] step_term;
	logic          item_acc, d_neg, is_r1, out_free;

	mre_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	mre_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid & ~item_stall;
	assign out_free   = ~res_valid_q | ~result_stall;
	assign d_neg      = d_q[DW-1];
	assign is_r1      = (phase_q == mre_pkg::PH_R1);
	assign t_val      = MW'({x_q, 1'b1});
	assign ym_val     = MW'(y_q - AW'(1));

	// slope term y is two's complement: it can run below zero after a shape change
	assign step_term = (sx_add_q ? DW'(sx_q) : '0) - (sy_sub_q ? DW'(signed'(sy_q)) : '0)
		+ DW'(is_r1 ? b2_q : a2_q);

	// multiplier operand selection
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_SQ_A: begin
				op_a = MW'(cfg.semi_axis_x);
				op_b = MW'(cfg.semi_axis_x);
			end
			ST_SQ_B: begin
				op_a = MW'(cfg.semi_axis_y);
				op_b = MW'(cfg.semi_axis_y);
			end
			ST_SQ_C: begin
				if (restart_q) begin
					op_a = MW'(a2_q);
					op_b = MW'(cfg.semi_axis_y);
				end else begin
					op_a = t_val;
					op_b = t_val;
				end
			end
			ST_TR_YY: begin
				op_a = ym_val;
				op_b = ym_val;
			end
			ST_TR_BT: begin
				op_a = MW'(b2_q);
				op_b = tmp_q;
			end
			ST_TR_AY: begin
				op_a = MW'(a2_q);
				op_b = tmp_q;
			end
			ST_TR_AB: begin
				op_a = MW'(a2_q);
				op_b = MW'(b2_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= mre_pkg::PH_DONE;
			x_q          <= '0;
			y_q          <= '0;
			sx_q         <= '0;
			sy_q         <= '0;
			d_q          <= '0;
			a2_q         <= '0;
			b2_q         <= '0;
			tmp_q        <= '0;
			restart_q    <= 1'b0;
			sx_add_q     <= 1'b0;
			sy_sub_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						restart_q <= restart;
						if (!restart && phase_q == mre_pkg::PH_DONE) begin
							pend_valid_q <= 1'b0;
							pend_last_q  <= 1'b0;
							state_q      <= ST_EMIT;
						end else begin
							state_q <= ST_SQ_A;
						end
					end
				end
				ST_SQ_A: state_q <= ST_SQ_B;
				ST_SQ_B: begin
					a2_q    <= QW'(prod);
					state_q <= ST_SQ_C;
				end
				ST_SQ_C: begin
					b2_q <= QW'(prod);
					priority if (restart_q) begin
						state_q <= ST_RS_SET;
					end else if (is_r1 && !(sx_q < sy_q)) begin
						state_q <= ST_TR_YY;
					end else begin
						state_q <= ST_UPD1;
					end
				end
				ST_RS_SET: begin
					x_q          <= '0;
					y_q          <= cfg.semi_axis_y;
					sx_q         <= '0;
					sy_q         <= SW'({prod, 1'b0});
					d_q          <= (DW'(b2_q) << 2) - (DW'(prod) << 2) + DW'(a2_q);
					phase_q      <= (cfg.semi_axis_y == '0) ? mre_pkg::PH_DONE : mre_pkg::PH_R1;
					pend_valid_q <= 1'b1;
					pend_last_q  <= (cfg.semi_axis_y == '0);
					state_q      <= ST_EMIT;
				end
				ST_TR_YY: begin
					tmp_q   <= MW'(prod);
					state_q <= ST_TR_BT;
				end
				ST_TR_BT: begin
					tmp_q   <= MW'(prod);
					state_q <= ST_TR_AY;
				end
				ST_TR_AY: begin
					d_q     <= DW'(prod);
					state_q <= ST_TR_AB;
				end
				ST_TR_AB: begin
					d_q     <= d_q + (DW'(prod) << 2);
					state_q <= ST_TR_FIN;
				end
				ST_TR_FIN: begin
					d_q     <= d_q - (DW'(prod) << 2);
					phase_q <= mre_pkg::PH_R2;
					state_q <= ST_UPD1;
				end
				ST_UPD1: begin
					sx_add_q <= is_r1 | d_neg;
					sy_sub_q <= ~is_r1 | ~d_neg;
					if (is_r1 || d_neg) begin
						x_q  <= x_q + AW'(1);
						sx_q <= sx_q + SW'({b2_q, 1'b0});
					end
					if (!is_r1 || !d_neg) begin
						y_q  <= y_q - AW'(1);
						sy_q <= sy_q - SW'({a2_q, 1'b0});
					end
					state_q <= ST_UPD2;
				end
				ST_UPD2: begin
					d_q          <= d_q + (step_term << 2);
					pend_valid_q <= 1'b1;
					pend_last_q  <= (y_q == '0);
					if (y_q == '0) begin
						phase_q <= mre_pkg::PH_DONE;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_right_q <= '0;
			res_left_q  <= '0;
			res_lower_q <= '0;
			res_upper_q <= '0;
			res_color_q <= '0;
			res_point_q <= 1'b0;
			res_last_q  <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				res_valid_q <= 1'b1;
				res_right_q <= pend_valid_q ? OW'(cfg.center_x) + OW'(x_q) : '0;
				res_left_q  <= pend_valid_q ? OW'(cfg.center_x) - OW'(x_q) : '0;
				res_lower_q <= pend_valid_q ? OW'(cfg.center_y) + OW'(y_q) : '0;
				res_upper_q <= pend_valid_q ? OW'(cfg.center_y) - OW'(y_q) : '0;
				res_color_q <= pend_valid_q ? cfg.pixel_color : '0;
				res_point_q <= pend_valid_q;
				res_last_q  <= pend_last_q;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign right_x      = res_right_q;
	assign left_x       = res_left_q;
	assign lower_y      = res_lower_q;
	assign upper_y      = res_upper_q;
	assign color_out    = res_color_q;
	assign point_valid  = res_point_q;
	assign last_point   = res_last_q;

	a_r1_only_from_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != mre_pkg::PH_R1 && state_q != ST_RS_SET) |=> (phase_q != mre_pkg::PH_R1))
		else $error("region 1 entered without a restart");

	a_last_has_point: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_point) |-> point_valid)
		else $error("last point flagged on an empty result");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_EMIT))
		else $error("result staged outside the emit step");

	a_done_stays_done: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == mre_pkg::PH_DONE && state_q != ST_RS_SET) |=> (phase_q == mre_pkg::PH_DONE))
		else $error("drawing resumed without a restart");

endmodule
